// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define CHK_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CHK_ASSERT(label, clk, rst, prop, msg)
`define CHK_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/core/scpr_pkg.sv -----
// Types and codes of the second-chance replacement queue
package scpr_pkg;
   typedef logic [1:0] mode_type;
   typedef logic [2:0] status_type;

   localparam mode_type MODE_ENQUEUE = 2'd0;
   localparam mode_type MODE_REMOVE  = 2'd1;
   localparam mode_type MODE_EVICT   = 2'd2;
   localparam mode_type MODE_MARK    = 2'd3;

   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_EMPTY      = 3'd1;
   localparam status_type STATUS_RANGE      = 3'd2;
   localparam status_type STATUS_QUEUED     = 3'd3;
   localparam status_type STATUS_NOT_QUEUED = 3'd4;

   localparam int FIELD_W  = 10;
   localparam int LIMIT_W  = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
endpackage

// ----- rtl/core/scpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module scpr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/core/second_chance_page_replacement.sv -----
// Second-chance page replacement queue: sequencer, link and flag memories
//
// The queue is a doubly linked list held in two link RAMs, with queued and
// referenced bits in two one-bit RAMs; head, tail and length sit in registers.
// Every RAM has registered read data, so each step is a read then a write.
// Enqueue, remove and mark read while idle, then write and set the result in
// S_OP. Evict reads the head while idle; each referenced head frame has its
// bit cleared and moves to the tail, until an unreferenced head is taken out.
// A clearing pass after reset zeroes the flag RAMs; no beat is accepted until
// it ends. A new beat is taken while the previous result is still waiting;
// the block only holds its final write cycle until the result register frees.
// Frames at or above min(limit_ff, FRAME_COUNT) are rejected.
`include "assert_macros.svh"
module second_chance_page_replacement
   import scpr_pkg::*;
#(
   parameter int FRAME_COUNT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [FIELD_W-1:0] req_frame_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [FIELD_W-1:0] rsp_victim_index,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);
   localparam int IW = $clog2(FRAME_COUNT);
   localparam int LW = $clog2(FRAME_COUNT + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_OP    = 3'd2;
   localparam logic [2:0] S_EV_RD = 3'd3;
   localparam logic [2:0] S_EV_DO = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [IW-1:0]      clr_ff, clr_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   mode_type           mode_ff, mode_in;
   logic [FIELD_W-1:0] frame_ff, frame_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [FIELD_W-1:0] victim_ff, victim_in;

   // memory ports
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] next_rd, prev_rd;
   logic          q_rd, r_rd;
   logic          next_we, prev_we, q_we, r_we;
   logic [IW-1:0] next_wa, prev_wa, q_wa, r_wa;
   logic [IW-1:0] next_wd, prev_wd;
   logic          q_wd, r_wd;

   logic          out_free, finish, in_rng;
   logic [IW-1:0] f_addr;
   status_type    fin_status;
   logic [FIELD_W-1:0] fin_victim;

   assign f_addr   = IW'(frame_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign in_rng   = (32'(frame_ff) < 32'(limit_ff)) && (32'(frame_ff) < FRAME_COUNT);
   assign req_ready = (state_ff == S_IDLE);

   // read address: from the request while idle (the head for evict), else the registered frame or the head
   always_comb begin
      rd_addr = head_ff;
      if (state_ff == S_IDLE) begin
         rd_addr = (req_mode == MODE_EVICT) ? head_ff : IW'(req_frame_index);
      end else if (state_ff == S_OP) begin
         rd_addr = f_addr;
      end
   end

   // sequencer: decides writes, register updates and the result
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      len_in     = len_ff;
      mode_in    = mode_ff;
      frame_in   = frame_ff;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      q_we       = 1'b0;
      r_we       = 1'b0;
      next_wa    = tail_ff;
      prev_wa    = f_addr;
      q_wa       = f_addr;
      r_wa       = f_addr;
      next_wd    = f_addr;
      prev_wd    = tail_ff;
      q_wd       = 1'b0;
      r_wd       = 1'b0;
      finish     = 1'b0;
      fin_status = STATUS_OK;
      fin_victim = '0;
      unique case (state_ff)
         S_CLEAR: begin
            q_we = 1'b1;
            r_we = 1'b1;
            q_wa = clr_ff;
            r_wa = clr_ff;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(FRAME_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               frame_in = req_frame_index;
               state_in = (req_mode == MODE_EVICT) ? S_EV_DO : S_OP;
            end
         end
         S_OP: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (!in_rng) begin
                  fin_status = STATUS_RANGE;
               end else begin
                  unique case (mode_ff)
                     MODE_ENQUEUE: begin
                        if (q_rd) begin
                           fin_status = STATUS_QUEUED;
                        end else begin
                           q_we = 1'b1;
                           q_wd = 1'b1;
                           if (len_ff != '0) begin
                              next_we = 1'b1;
                              prev_we = 1'b1;
                           end else begin
                              head_in = f_addr;
                           end
                           tail_in = f_addr;
                           len_in  = len_ff + LW'(1);
                        end
                     end
                     MODE_REMOVE: begin
                        if (!q_rd) begin
                           fin_status = STATUS_NOT_QUEUED;
                        end else begin
                           q_we = 1'b1;
                           if (f_addr != head_ff) begin
                              next_we = 1'b1;
                              next_wa = prev_rd;
                              next_wd = next_rd;
                           end else begin
                              head_in = next_rd;
                           end
                           if (f_addr != tail_ff) begin
                              prev_we = 1'b1;
                              prev_wa = next_rd;
                              prev_wd = prev_rd;
                           end else begin
                              tail_in = prev_rd;
                           end
                           len_in = len_ff - LW'(1);
                           if (len_ff == LW'(1)) begin
                              head_in = '0;
                              tail_in = '0;
                           end
                        end
                     end
                     MODE_MARK: begin
                        r_we = 1'b1;
                        r_wd = 1'b1;
                     end
                     default: begin
                        fin_status = STATUS_OK;
                     end
                  endcase
               end
            end
         end
         S_EV_RD: begin
            state_in = S_EV_DO;
         end
         S_EV_DO: begin
            if (len_ff == '0) begin
               if (out_free) begin
                  finish     = 1'b1;
                  fin_status = STATUS_EMPTY;
                  state_in   = S_IDLE;
               end
            end else if (r_rd) begin
               // second chance: clear the bit and move head to tail
               r_we = 1'b1;
               r_wa = head_ff;
               if (len_ff != LW'(1)) begin
                  next_we = 1'b1;
                  next_wd = head_ff;
                  prev_we = 1'b1;
                  prev_wa = head_ff;
                  head_in = next_rd;
                  tail_in = head_ff;
               end
               state_in = S_EV_RD;
            end else if (out_free) begin
               finish     = 1'b1;
               fin_victim = FIELD_W'(head_ff);
               state_in   = S_IDLE;
               q_we       = 1'b1;
               q_wa       = head_ff;
               head_in    = next_rd;
               len_in     = len_ff - LW'(1);
               if (len_ff == LW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register and configuration
   assign rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign status_in    = finish ? fin_status : status_ff;
   assign victim_in    = finish ? fin_victim : victim_ff;
   assign limit_in     = csr_write_enable ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      frame_ff  <= frame_in;
      status_ff <= status_in;
      victim_ff <= victim_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_victim_index = victim_ff;

   // link and flag memories
   scpr_ram #(.WIDTH(IW), .DEPTH(FRAME_COUNT)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(next_rd)
   );
   scpr_ram #(.WIDTH(IW), .DEPTH(FRAME_COUNT)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(prev_rd)
   );
   scpr_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_queued_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(rd_addr), .rd_data(q_rd)
   );
   scpr_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_ref_ram (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(rd_addr), .rd_data(r_rd)
   );

   // checks
   `CHK_ASSERT(a_len_max, clock, reset, len_ff <= LW'(FRAME_COUNT), "queue length overflow")
   `CHK_ASSERT(a_empty_ptrs, clock, reset, (len_ff == '0) |-> (head_ff == '0 && tail_ff == '0), "empty queue with stale pointers")
   `CHK_NEVER(a_no_overwrite, clock, reset, finish && rsp_valid_ff && !rsp_ready, "result overwritten")
   `CHK_ASSERT(a_evict_len, clock, reset, (finish && state_ff == S_EV_DO && len_ff != '0) |=> (len_ff == $past(len_ff) - LW'(1)), "evict did not shorten queue")
endmodule
